@@ sv/hco_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hco_pkg
// Shared types and constants for the Ore-condition Hamiltonian cycle builder.
// ----------------------------------------------------------------------------
package hco_pkg;

  localparam int unsigned VERTEX_W = 7;
  localparam int unsigned COUNT_W  = 7;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT_WR,
    OP_PASS_RD,
    OP_ADJ_V,
    OP_SRCH_START,
    OP_SRCH_RD,
    OP_ADJ_S,
    OP_SRCH_NEXT,
    OP_SWAP_START,
    OP_SWAP_RD,
    OP_SWAP_W1,
    OP_SWAP_W2,
    OP_ADV,
    OP_FAIL,
    OP_EMIT_RD,
    OP_EMIT_LD,
    OP_EMIT_NEXT
  } hco_op_t;

  typedef struct packed {
    hco_op_t op;
  } hco_cmd_t;

  typedef struct packed {
    logic run_start;   // last triangle bit taken this cycle
    logic init_done;   // identity fill writes its last entry
    logic joined;      // front pair adjacent
    logic srch_first;  // a first candidate j exists
    logic srch_hit;    // candidate j satisfies both edges
    logic srch_more;   // another candidate j exists
    logic swap_more;   // reversal needs another swap
    logic pass_last;   // this pass completes the pass budget
    logic emit_last;   // current emit index is the final vertex
  } hco_stat_t;

endpackage

@@ sv/hco_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hco_datapath
// Adjacency store, circular vertex order store, counters and result register.
// ----------------------------------------------------------------------------
module hco_datapath
  import hco_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hco_cmd_t            cmd,
  output hco_stat_t           stat,
  input  logic                in_valid,
  input  logic                in_edge_bit,
  input  logic                cfg_valid,
  input  logic [COUNT_W-1:0]  cfg_vertex_count,
  output logic [VERTEX_W-1:0] out_vertex,
  output logic                out_last,
  output logic                out_failed
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int SW = IW + 1;
  localparam int EW = IW + 2;
  localparam int PW = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) + 1);

  // circular index: s is below 2n
  function automatic logic [IW-1:0] wrap_idx(input logic [SW-1:0] s, input logic [SW-1:0] n);
    logic [SW-1:0] d;
    d = s - n;
    return (s >= n) ? d[IW-1:0] : s[IW-1:0];
  endfunction

  logic [COUNT_W-1:0]      vc_r;
  logic [NW-1:0]           load_row_r;
  logic [IW-1:0]           load_col_r;
  logic [MAX_VERTICES-1:0] row_buf_r;
  logic [IW-1:0]           head_r, k_r, j_r, lo_r, hi_r;
  logic [PW-1:0]           pass_r, total_r;
  logic                    failed_r;
  logic [IW-1:0]           q0_r, q1_r, v1_r, v2_r;
  logic [MAX_VERTICES-1:0] adj_a_r, adj_b_r;
  logic [IW-1:0]           bit_a_r, bit_b_r;
  logic [VERTEX_W-1:0]     out_vertex_r;
  logic                    out_last_r, out_failed_r;

  logic [MAX_VERTICES-1:0] adj_mem   [MAX_VERTICES];
  logic [IW-1:0]           order_mem [MAX_VERTICES];

  logic [NW-1:0]           n_eff;
  logic [SW-1:0]           n_s;
  logic                    fire, row_end, run_start;
  logic [NW-1:0]           row_next;
  logic [MAX_VERTICES-1:0] row_data;
  logic [2*NW-1:0]         prod;
  logic [IW-1:0]           idx0, idx1, raddr0, raddr1;
  logic                    rd_en, adj_en, ord_we;
  logic [IW-1:0]           ord_waddr, ord_wdata;
  logic [IW-1:0]           pa1, pb1, pa2, pb2;
  logic [IW-1:0]           row_a, row_b, min_a, min_b;

  // clamp vertex count
  always_comb begin
    if (vc_r < COUNT_W'(2)) begin
      n_eff = NW'(2);
    end else if (vc_r > COUNT_W'(MAX_VERTICES)) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vc_r);
    end
  end
  assign n_s  = SW'(n_eff);
  assign prod = {{NW{1'b0}}, n_eff} * {{NW{1'b0}}, n_eff - NW'(1)};

  // triangle loading
  assign fire      = (cmd.op == OP_LOAD) && in_valid;
  assign row_end   = (SW'(load_col_r) + SW'(1)) == SW'(load_row_r);
  assign row_next  = load_row_r + NW'(1);
  assign run_start = fire && row_end && (row_next >= n_eff);

  always_comb begin
    row_data = row_buf_r;
    row_data[load_col_r] = in_edge_bit;
  end

  // order store read indices
  always_comb begin
    idx0  = '0;
    idx1  = '0;
    rd_en = 1'b0;
    unique case (cmd.op)
      OP_PASS_RD: begin
        idx1  = IW'(1);
        rd_en = 1'b1;
      end
      OP_SRCH_RD: begin
        idx0  = j_r + IW'(1);
        idx1  = j_r + IW'(2);
        rd_en = 1'b1;
      end
      OP_SWAP_RD: begin
        idx0  = lo_r;
        idx1  = hi_r;
        rd_en = 1'b1;
      end
      OP_EMIT_RD: begin
        idx0  = k_r;
        idx1  = k_r;
        rd_en = 1'b1;
      end
      default: ;
    endcase
  end
  assign raddr0 = wrap_idx(SW'(head_r) + SW'(idx0), n_s);
  assign raddr1 = wrap_idx(SW'(head_r) + SW'(idx1), n_s);

  // order store write port
  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = '0;
    ord_wdata = '0;
    unique case (cmd.op)
      OP_INIT_WR: begin
        ord_we    = 1'b1;
        ord_waddr = k_r;
        ord_wdata = k_r;
      end
      OP_SWAP_W1: begin
        ord_we    = 1'b1;
        ord_waddr = wrap_idx(SW'(head_r) + SW'(lo_r), n_s);
        ord_wdata = q1_r;
      end
      OP_SWAP_W2: begin
        ord_we    = 1'b1;
        ord_waddr = wrap_idx(SW'(head_r) + SW'(hi_r), n_s);
        ord_wdata = q0_r;
      end
      default: ;
    endcase
  end

  // adjacency pairs: lower triangle, row is the larger vertex
  always_comb begin
    adj_en = 1'b0;
    pa1 = q0_r;
    pb1 = q1_r;
    pa2 = q0_r;
    pb2 = q1_r;
    unique case (cmd.op)
      OP_ADJ_V: adj_en = 1'b1;
      OP_ADJ_S: begin
        adj_en = 1'b1;
        pa1 = v1_r;
        pb1 = q0_r;
        pa2 = v2_r;
        pb2 = q1_r;
      end
      default: ;
    endcase
  end
  assign row_a = (pa1 > pb1) ? pa1 : pb1;
  assign min_a = (pa1 > pb1) ? pb1 : pa1;
  assign row_b = (pa2 > pb2) ? pa2 : pb2;
  assign min_b = (pa2 > pb2) ? pb2 : pa2;

  // memories
  always_ff @(posedge clk) begin
    if (fire && row_end) begin
      adj_mem[load_row_r[IW-1:0]] <= row_data;
    end
    if (adj_en) begin
      adj_a_r <= adj_mem[row_a];
      adj_b_r <= adj_mem[row_b];
      bit_a_r <= min_a;
      bit_b_r <= min_b;
    end
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      order_mem[ord_waddr] <= ord_wdata;
    end
    if (rd_en) begin
      q0_r <= order_mem[raddr0];
      q1_r <= order_mem[raddr1];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (fire) begin
      row_buf_r <= row_data;
    end
    if (cmd.op == OP_ADJ_V) begin
      v1_r <= q0_r;
      v2_r <= q1_r;
    end
    if (cmd.op == OP_EMIT_LD) begin
      out_vertex_r <= VERTEX_W'(q0_r) + VERTEX_W'(1);
      out_last_r   <= stat.emit_last;
      out_failed_r <= failed_r;
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r       <= COUNT_RESET;
      load_row_r <= NW'(1);
      load_col_r <= '0;
      head_r     <= '0;
      k_r        <= '0;
      j_r        <= '0;
      lo_r       <= '0;
      hi_r       <= '0;
      pass_r     <= '0;
      total_r    <= '0;
      failed_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        vc_r       <= cfg_vertex_count;
        load_row_r <= NW'(1);
        load_col_r <= '0;
      end else if (fire) begin
        if (row_end) begin
          load_row_r <= run_start ? NW'(1) : row_next;
          load_col_r <= '0;
        end else begin
          load_col_r <= load_col_r + IW'(1);
        end
      end
      if (run_start) begin
        head_r   <= '0;
        k_r      <= '0;
        pass_r   <= '0;
        failed_r <= 1'b0;
        total_r  <= prod[PW-1:0];
      end
      unique case (cmd.op)
        OP_INIT_WR:    k_r <= k_r + IW'(1);
        OP_SRCH_START: j_r <= IW'(1);
        OP_SRCH_NEXT:  j_r <= j_r + IW'(1);
        OP_SWAP_START: begin
          lo_r <= IW'(1);
          hi_r <= j_r + IW'(1);
        end
        OP_SWAP_W2: begin
          lo_r <= lo_r + IW'(1);
          hi_r <= hi_r - IW'(1);
        end
        OP_ADV: begin
          head_r <= wrap_idx(SW'(head_r) + SW'(1), n_s);
          pass_r <= pass_r + PW'(1);
          k_r    <= '0;
        end
        OP_FAIL: begin
          failed_r <= 1'b1;
          k_r      <= '0;
        end
        OP_EMIT_NEXT:  k_r <= k_r + IW'(1);
        default: ;
      endcase
    end
  end

  // status to controller
  assign stat.run_start  = run_start;
  assign stat.init_done  = (SW'(k_r) + SW'(1)) == n_s;
  assign stat.joined     = adj_a_r[bit_a_r];
  assign stat.srch_first = EW'(n_eff) >= EW'(4);
  assign stat.srch_hit   = adj_a_r[bit_a_r] && adj_b_r[bit_b_r];
  assign stat.srch_more  = (EW'(j_r) + EW'(4)) <= EW'(n_eff);
  assign stat.swap_more  = (EW'(lo_r) + EW'(2)) < EW'(hi_r);
  assign stat.pass_last  = (pass_r + PW'(1)) == total_r;
  assign stat.emit_last  = (SW'(k_r) + SW'(1)) == n_s;

  assign out_vertex = out_vertex_r;
  assign out_last   = out_last_r;
  assign out_failed = out_failed_r;

endmodule

@@ sv/hco_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hco_ctrl
// Sequencer for load, identity fill, rotation passes, rotation search, reversal, failure and emit.
// ----------------------------------------------------------------------------
module hco_ctrl
  import hco_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  hco_stat_t stat,
  input  logic      out_ready,
  output hco_cmd_t  cmd,
  output logic      in_ready,
  output logic      out_valid
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT,
    S_PASS_RD,
    S_PASS_ADJ,
    S_PASS_CHK,
    S_SRCH_RD,
    S_SRCH_ADJ,
    S_SRCH_CHK,
    S_SWAP_RD,
    S_SWAP_W1,
    S_SWAP_W2,
    S_ADV,
    S_FAIL,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  // operation decode
  always_comb begin
    cmd.op = OP_NONE;
    unique case (state_r)
      S_LOAD:      cmd.op = OP_LOAD;
      S_INIT:      cmd.op = OP_INIT_WR;
      S_PASS_RD:   cmd.op = OP_PASS_RD;
      S_PASS_ADJ:  cmd.op = OP_ADJ_V;
      S_PASS_CHK:  cmd.op = stat.joined ? OP_NONE : OP_SRCH_START;
      S_SRCH_RD:   cmd.op = OP_SRCH_RD;
      S_SRCH_ADJ:  cmd.op = OP_ADJ_S;
      S_SRCH_CHK:  cmd.op = stat.srch_hit ? OP_SWAP_START : OP_SRCH_NEXT;
      S_SWAP_RD:   cmd.op = OP_SWAP_RD;
      S_SWAP_W1:   cmd.op = OP_SWAP_W1;
      S_SWAP_W2:   cmd.op = OP_SWAP_W2;
      S_ADV:       cmd.op = OP_ADV;
      S_FAIL:      cmd.op = OP_FAIL;
      S_EMIT_RD:   cmd.op = OP_EMIT_RD;
      S_EMIT_LD:   cmd.op = OP_EMIT_LD;
      S_EMIT_WAIT: cmd.op = out_ready ? OP_EMIT_NEXT : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD:     if (stat.run_start) state_r <= S_INIT;
        S_INIT:     if (stat.init_done) state_r <= S_PASS_RD;
        S_PASS_RD:  state_r <= S_PASS_ADJ;
        S_PASS_ADJ: state_r <= S_PASS_CHK;
        S_PASS_CHK: begin
          if (stat.joined) begin
            state_r <= S_ADV;
          end else begin
            state_r <= stat.srch_first ? S_SRCH_RD : S_FAIL;
          end
        end
        S_SRCH_RD:  state_r <= S_SRCH_ADJ;
        S_SRCH_ADJ: state_r <= S_SRCH_CHK;
        S_SRCH_CHK: begin
          if (stat.srch_hit) begin
            state_r <= S_SWAP_RD;
          end else begin
            state_r <= stat.srch_more ? S_SRCH_RD : S_FAIL;
          end
        end
        S_SWAP_RD:  state_r <= S_SWAP_W1;
        S_SWAP_W1:  state_r <= S_SWAP_W2;
        S_SWAP_W2:  state_r <= stat.swap_more ? S_SWAP_RD : S_ADV;
        S_ADV:      state_r <= stat.pass_last ? S_EMIT_RD : S_PASS_RD;
        S_FAIL:     state_r <= S_EMIT_RD;
        S_EMIT_RD:  state_r <= S_EMIT_LD;
        S_EMIT_LD: begin
          state_r     <= S_EMIT_WAIT;
          out_valid_r <= 1'b1;
        end
        S_EMIT_WAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= stat.emit_last ? S_LOAD : S_EMIT_RD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

@@ sv/hamiltonian_cycle_ore_rotation.sv @@
`timescale 1ns / 1ps
// Load: one adjacency bit per cycle; the bit that completes the triangle starts a run.
// Run: identity fill of the order store, then n*(n-1) passes; each pass checks the front
// pair and, when it is not adjacent, searches for a j and reverses a segment by swaps.
// Emit: each vertex is held until the sink takes it; input is held off during run and emit.
// Timing is set by the single sequencer and the two-read, one-write order store.
// Reset: synchronous active low; vertex_count returns to 64, loading restarts at row 1.
// ----------------------------------------------------------------------------
// hamiltonian_cycle_ore_rotation
// Builds a Hamiltonian cycle by rotation for graphs meeting Ore's condition.
// ----------------------------------------------------------------------------
module hamiltonian_cycle_ore_rotation
  import hco_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_edge_bit,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_vertex_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VERTEX_W-1:0] out_vertex,
  output logic                out_last,
  output logic                out_failed
);

  hco_cmd_t  cmd;
  hco_stat_t stat;

  // register writes always taken
  assign cfg_ready = 1'b1;

  hco_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (stat),
    .out_ready (out_ready),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  hco_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_edge_bit      (in_edge_bit),
    .cfg_valid        (cfg_valid),
    .cfg_vertex_count (cfg_vertex_count),
    .out_vertex       (out_vertex),
    .out_last         (out_last),
    .out_failed       (out_failed)
  );

  // input and output sides never open together
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result word is pending");

  // emitted vertex numbers stay in range
  a_vertex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_vertex != '0) && (out_vertex <= VERTEX_W'(MAX_VERTICES)))
    else $error("result vertex out of range");

  // after the final word is taken, loading resumes
  a_last_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready)
    else $error("load not resumed after final vertex");

endmodule
